### hw/rtl/rws_pkg.sv
package rws_pkg;

  // Score table entry width
  localparam int unsigned ENTRY_W = 14;

  // Cumulative shares are scaled to about this total
  localparam int unsigned SHARE_SCALE = 100;

  // Opcodes
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_NORMALIZE = 2'd1;
  localparam logic [1:0] OP_CHOOSE    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEMBER = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] member_index;
    logic [6:0] fitness_value;
    logic [6:0] draw;
  } in_t;

  typedef struct packed {
    logic [6:0] chosen_member;
    logic [1:0] status;
  } out_t;

endpackage

### hw/rtl/roulette_wheel_selector.sv
// Roulette wheel (fitness-proportional) selector. A write transaction stores
// one member's fitness in a MEMBERS x 14-bit score table held in a single-port
// synchronous RAM. A normalize transaction sums the table, rounds the sum down
// to even, divides by 100 and rewrites every entry in place with the running
// total of entry / divisor; if the divisor is zero it returns status 2 and
// leaves the table alone. A choose transaction returns the lowest member whose
// cumulative value exceeds the draw, or status 1 if none does. Every input
// transaction yields exactly one result transaction. Entries must be written
// before a normalize or choose reads them; the RAM is not cleared at reset.
// One transaction is processed at a time; the next is accepted as soon as the
// previous result sits in the output register. A write or an unused opcode
// goes straight to its result; a choose reads entries from index 0 upward
// until one qualifies or the table ends; a normalize reads every entry once
// to sum and, unless the divisor is zero, once more to divide and write back.
// Each entry costs a registered RAM read and, in the second normalize pass,
// the bit-serial divider, which spends 14 steps on each entry. The divisor
// sum / 100 itself comes from one combinational reciprocal multiply.
module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int unsigned MEMBERS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,

  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned IDX_W  = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  // Table sum width: MEMBERS entries of 14 bits
  localparam int unsigned SW     = ENTRY_W + IDX_W;
  // sum / 100 < 2^(SW-6)
  localparam int unsigned DVS_W  = SW - 6;
  localparam int unsigned STEP_W = $clog2(ENTRY_W);
  // sum / 100 as (sum * RECIP) >> RSH; exact for any SW-bit sum because
  // RECIP * 100 overshoots 2^RSH by less than 2^7
  localparam int unsigned RSH    = SW + 7;
  localparam logic [SW:0] RECIP  =
    (SW+1)'(((64'd1 << RSH) + 64'(SHARE_SCALE) - 64'd1) / 64'(SHARE_SCALE));

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV_SUM,
    S_NRM_RD,
    S_NRM_LD,
    S_DIV_ENT,
    S_CH_RD,
    S_CH_CMP,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   cnt_q;
  logic [SW-1:0]      sum_q;
  logic [DVS_W-1:0]   divisor_q;
  logic [ENTRY_W-1:0] run_q;
  logic [6:0]         draw_q;
  out_t               res_q;
  logic               out_valid_q;
  out_t               out_data_q;

  // Bit-serial restoring divider for entry / divisor
  logic [DVS_W-1:0]   rem_q;
  logic [ENTRY_W-1:0] quo_q;
  logic [STEP_W-1:0]  step_q;

  // Score table RAM
  logic [ENTRY_W-1:0] mem [MEMBERS];
  logic [ENTRY_W-1:0] mem_rdata_q;
  logic               mem_re;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               in_fire;
  logic               out_free;
  logic               cnt_last;
  logic [SW-1:0]      sum_next;
  logic [2*SW:0]      sum_prod;
  logic [DVS_W-1:0]   sum_quo;
  logic [DVS_W:0]     rem_sh;
  logic               div_ge;
  logic [DVS_W:0]     div_diff;
  logic [DVS_W-1:0]   rem_d;
  logic [ENTRY_W-1:0] quo_d;
  logic               div_last;
  logic [ENTRY_W-1:0] run_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign cnt_last = (cnt_q == IDX_W'(MEMBERS - 1));
  assign sum_next = sum_q + SW'(mem_rdata_q);

  // Divisor from the even-rounded sum held in sum_q
  assign sum_prod = {{(SW+1){1'b0}}, sum_q} * {{SW{1'b0}}, RECIP};
  assign sum_quo  = sum_prod[RSH +: DVS_W];

  // One divider step: shift in next dividend bit, trial subtract
  assign rem_sh   = {rem_q, quo_q[ENTRY_W-1]};
  assign div_diff = rem_sh - {1'b0, divisor_q};
  assign div_ge   = (rem_sh >= {1'b0, divisor_q});
  assign rem_d    = div_ge ? div_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign quo_d    = {quo_q[ENTRY_W-2:0], div_ge};
  assign div_last = (step_q == STEP_W'(ENTRY_W - 1));

  assign run_next = run_q + quo_d;

  // RAM port control. Normalize writes entry k back before entry k+1 is
  // read, so read and write never overlap on one entry.
  always_comb begin
    mem_re    = (state_q == S_SUM_RD) || (state_q == S_NRM_RD) ||
                (state_q == S_CH_RD);
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = run_next;
    if (in_fire && (in_data_i.opcode == OP_WRITE) &&
        (32'(in_data_i.member_index) < MEMBERS)) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(in_data_i.member_index);
      mem_wdata = ENTRY_W'(in_data_i.fitness_value);
    end else if ((state_q == S_DIV_ENT) && div_last) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      divisor_q   <= '0;
      run_q       <= '0;
      draw_q      <= '0;
      res_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // A new result loaded in S_DONE takes the place of the one leaving
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            draw_q <= in_data_i.draw;
            res_q  <= '0;
            cnt_q  <= '0;
            sum_q  <= '0;
            run_q  <= '0;
            unique case (in_data_i.opcode)
              OP_NORMALIZE: state_q <= S_SUM_RD;
              OP_CHOOSE:    state_q <= S_CH_RD;
              default:      state_q <= S_DONE;
            endcase
          end
        end
        S_SUM_RD: begin
          state_q <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          if (cnt_last) begin
            // Round odd sum down to even
            sum_q   <= {sum_next[SW-1:1], 1'b0};
            state_q <= S_DIV_SUM;
          end else begin
            sum_q   <= sum_next;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_DIV_SUM: begin
          if (sum_quo == '0) begin
            res_q.status <= ST_DIV_ZERO;
            state_q      <= S_DONE;
          end else begin
            divisor_q <= sum_quo;
            cnt_q     <= '0;
            state_q   <= S_NRM_RD;
          end
        end
        S_NRM_RD: begin
          state_q <= S_NRM_LD;
        end
        S_NRM_LD: begin
          rem_q   <= '0;
          quo_q   <= mem_rdata_q;
          step_q  <= '0;
          state_q <= S_DIV_ENT;
        end
        S_DIV_ENT: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          step_q <= step_q + 1'b1;
          if (div_last) begin
            run_q <= run_next;
            if (cnt_last) begin
              state_q <= S_DONE;
            end else begin
              cnt_q   <= cnt_q + 1'b1;
              state_q <= S_NRM_RD;
            end
          end
        end
        S_CH_RD: begin
          state_q <= S_CH_CMP;
        end
        S_CH_CMP: begin
          if (ENTRY_W'(draw_q) < mem_rdata_q) begin
            res_q.chosen_member <= 7'(cnt_q);
            state_q             <= S_DONE;
          end else if (cnt_last) begin
            res_q.status <= ST_NO_MEMBER;
            state_q      <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_CH_RD;
          end
        end
        S_DONE: begin
          // Hold until the output register frees up
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### hw/rtl/rws_checker.sv
module rws_checker
  import rws_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One transaction in flight: stall right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) ||
                    (out_data_o.status == ST_NO_MEMBER) ||
                    (out_data_o.status == ST_DIV_ZERO))
    else $error("undefined status code");

  // Error results carry no member
  a_err_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.chosen_member == '0)
    else $error("member reported with error status");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);

### bench/rws_selection_checker.sv
module rws_selection_checker
  import rws_pkg::*;
#(
  parameter int unsigned MEMBERS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,

  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow of the score table, raw fitness or cumulative shares
  logic [ENTRY_W-1:0] shadow_scores [MEMBERS];
  out_t               expected_picks [$];
  out_t               oldest_pick;
  int unsigned        mismatches;

  // Applies one transaction to the shadow table and returns the result it must produce
  function automatic out_t predict_selection(in_t t);
    out_t               pick;
    logic [31:0]        total;
    logic [31:0]        divisor;
    logic [ENTRY_W-1:0] running;
    pick = '0;
    case (t.opcode)
      OP_WRITE: begin
        if (t.member_index < MEMBERS) shadow_scores[t.member_index] = ENTRY_W'(t.fitness_value);
      end
      OP_NORMALIZE: begin
        total = '0;
        for (int k = 0; k < MEMBERS; k++) total = total + shadow_scores[k];
        total[0] = 1'b0;
        divisor = total / SHARE_SCALE;
        if (divisor == '0) begin
          pick.status = ST_DIV_ZERO;
        end else begin
          running = '0;
          for (int k = 0; k < MEMBERS; k++) begin
            running = ENTRY_W'(running + shadow_scores[k] / divisor);
            shadow_scores[k] = running;
          end
        end
      end
      OP_CHOOSE: begin
        // scan downward so the lowest qualifying index wins
        pick.status = ST_NO_MEMBER;
        for (int k = MEMBERS - 1; k >= 0; k--) begin
          if (t.draw < shadow_scores[k]) begin
            pick.status        = ST_OK;
            pick.chosen_member = 7'(k);
          end
        end
      end
      default: ;
    endcase
    return pick;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_picks.delete();
      mismatches = 0;
      for (int k = 0; k < MEMBERS; k++) shadow_scores[k] = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_picks.push_back(predict_selection(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result member %0d status %0d", $time,
                   out_data_i.chosen_member, out_data_i.status);
          mismatches++;
        end else begin
          oldest_pick = expected_picks.pop_front();
          if (out_data_i.status !== oldest_pick.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     oldest_pick.status, out_data_i.status);
            mismatches++;
          end
          if (out_data_i.chosen_member !== oldest_pick.chosen_member) begin
            $display("%0t: chosen_member expected %0d got %0d", $time,
                     oldest_pick.chosen_member, out_data_i.chosen_member);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_picks.size();
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import rws_pkg::*;

  localparam int unsigned MEMBERS      = 128;
  // Random stimulus stops once this many transactions went in after the directed part
  localparam int unsigned RANDOM_ITEMS = 1750;
  // Worst case: ~2000 transactions, every one as slow as a normalize, plus
  // random stalls on both sides. The limit is four times that worst case.
  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  // Opcode with no function; the block answers it with an ok status
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  int unsigned failures;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned items_sent;
  // set during a window of episodes: no idling on either side
  logic        quiet;

  roulette_wheel_selector #(
    .MEMBERS(MEMBERS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  rws_selection_checker #(
    .MEMBERS(MEMBERS)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(failures),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side: stall about 16% of cycles, never while quiet
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 16);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic in_t make_item(logic [1:0] op, logic [6:0] idx, logic [6:0] fit,
                                    logic [6:0] drw);
    in_t t;
    t.opcode        = op;
    t.member_index  = idx;
    t.fitness_value = fit;
    t.draw          = drw;
    return t;
  endfunction

  // Present one transaction and hold it until accepted. Idle cycles come
  // before the transaction; if none, valid simply stays high from the last one.
  task automatic send(in_t t);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Unused fields of each opcode carry random bits
  task automatic put_score(int idx, int fit);
    send(make_item(OP_WRITE, 7'(idx), 7'(fit), 7'($urandom_range(127))));
  endtask

  task automatic rescale();
    send(make_item(OP_NORMALIZE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                   7'($urandom_range(127))));
  endtask

  task automatic spin(int drw);
    send(make_item(OP_CHOOSE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                   7'(drw)));
  endtask

  initial begin : stimulus
    int unsigned directed_end;
    int          episode;
    int          profile;
    int          roll;
    int          passes;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    items_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is not cleared at reset: write every entry before any read
    for (int i = 0; i < MEMBERS; i++) put_score(i, 0);

    // Directed corners
    spin(0);                  // all-zero table: nothing exceeds the draw
    rescale();                // sum zero -> zero divisor
    put_score(64, 99);
    rescale();                // odd sum 99 rounds to 98, still a zero divisor
    put_score(0, 127);        // sum 226 -> divisor 2: shares 63 and 49
    put_score(127, 0);
    rescale();
    spin(0);                  // first member
    spin(62);                 // last draw below member 0's share
    spin(63);                 // lands on member 64
    spin(111);
    spin(112);                // equals the top total: miss
    spin(127);                // largest draw
    send(make_item(OP_UNUSED, 7'h7F, 7'h7F, 7'h7F));
    put_score(127, 127);      // largest fitness, highest index
    spin(0);
    rescale();                // renormalize a cumulative table
    spin(0);
    spin(63);
    spin(98);
    directed_end = items_sent;

    // Random episodes: refill part or all of the table, normalize up to twice,
    // then a burst of chooses with some noise mixed in
    episode = 0;
    while (items_sent < directed_end + RANDOM_ITEMS) begin
      quiet   <= (episode >= 6 && episode < 10);
      profile = $urandom_range(3);
      case (profile)
        0: begin
          // dense random rewrite: large sum, small shares
          repeat ($urandom_range(1, MEMBERS)) put_score($urandom_range(127), $urandom_range(127));
        end
        1: begin
          // sparse table: a few members carry all the weight
          for (int i = 0; i < MEMBERS; i++)
            put_score(i, ($urandom_range(99) < 85) ? 0 : $urandom_range(127));
        end
        2: begin
          // tiny values: sum hovers around the zero-divisor boundary
          for (int i = 0; i < MEMBERS; i++) put_score(i, $urandom_range(2));
        end
        default: begin
          // touch only a few entries of whatever is there
          repeat ($urandom_range(1, 8)) put_score($urandom_range(127), $urandom_range(127));
        end
      endcase

      passes = ($urandom_range(9) == 0) ? 0 : (($urandom_range(4) == 0) ? 2 : 1);
      repeat (passes) rescale();

      repeat ($urandom_range(8, 30)) begin
        roll = $urandom_range(99);
        if (roll < 8)
          send(make_item(OP_UNUSED, 7'($urandom_range(127)), 7'($urandom_range(127)),
                         7'($urandom_range(127))));
        else if (roll < 14)
          put_score($urandom_range(127), $urandom_range(127));
        else
          spin((roll < 85) ? $urandom_range(98) : $urandom_range(127));
      end
      episode++;
    end

    // Drop valid at the step of the last accept, then drain
    in_valid <= 1'b0;
    quiet    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rws_pkg.sv
hw/rtl/roulette_wheel_selector.sv
hw/rtl/rws_checker.sv
bench/rws_selection_checker.sv
bench/tb_top.sv
